### src/fcpu_pkg.sv
// fcpu_pkg: shared constants, opcodes and arithmetic helpers of the fly camera
// pose keeper; no dependencies
package fcpu_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  // event opcodes
  localparam logic [1:0] OP_MOVE   = 2'd0;
  localparam logic [1:0] OP_LOOK   = 2'd1;
  localparam logic [1:0] OP_SCROLL = 2'd2;
  localparam logic [1:0] OP_HOME   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_INIT_X = 3'd0;
  localparam logic [2:0] REG_INIT_Y = 3'd1;
  localparam logic [2:0] REG_INIT_Z = 3'd2;
  localparam logic [2:0] REG_SPEED  = 3'd3;
  localparam logic [2:0] REG_GAIN   = 3'd4;

  localparam logic [31:0] SPEED_RST = 32'd163840;
  localparam logic [15:0] GAIN_RST  = 16'd6554;
  localparam logic [31:0] SPEED_MIN = 32'd65536;

  localparam logic signed [24:0] YAW_HOME  = -25'sd5898240;
  localparam logic [33:0]        YAW_HALF  = 34'd11796480;
  localparam logic [33:0]        YAW_FULL  = 34'd23592960;
  localparam logic signed [33:0] PITCH_LIM = 34'sd5832704;

  localparam logic signed [15:0] UNIT_POS = 16'sd16384;
  localparam logic signed [15:0] UNIT_NEG = -16'sd16384;

  localparam longint GAIN_Q24    = 64'd10188014;
  localparam longint DEG_RAD_Q24 = 64'd961263669;

  // arctangent of 2^-i in degrees, 24 fraction bits
  function automatic logic [29:0] atan_q24(input logic [4:0] i);
    logic [29:0] a;
    unique case (i)
      5'd0:    a = 30'd754974720;
      5'd1:    a = 30'd445687602;
      5'd2:    a = 30'd235489088;
      5'd3:    a = 30'd119537938;
      5'd4:    a = 30'd60000934;
      5'd5:    a = 30'd30029717;
      5'd6:    a = 30'd15018523;
      5'd7:    a = 30'd7509720;
      5'd8:    a = 30'd3754917;
      5'd9:    a = 30'd1877466;
      5'd10:   a = 30'd938734;
      5'd11:   a = 30'd469367;
      default: a = 30'(DEG_RAD_Q24 >> i);
    endcase
    return a;
  endfunction

  // shift right rounding half away from zero
  function automatic logic signed [51:0] rnd_shr(input logic signed [51:0] p, input int s);
    logic signed [51:0] bias;
    bias = (52'sd1 <<< (s - 1)) - (p[51] ? 52'sd1 : 52'sd0);
    return (p + bias) >>> s;
  endfunction

  // saturate to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) r = 32'sh7fffffff;
    else if (v < -37'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // result of one cordic run
  typedef struct packed {
    logic               done;
    logic signed [15:0] sin;
    logic signed [15:0] cos;
  } cordic_res_t;

endpackage

### src/fcpu_cmd_if.sv
// fcpu_cmd_if: event channel of the fly camera pose keeper
// depends on nothing
interface fcpu_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [5:0]         key_mask;
  logic [15:0]        delta_time;
  logic signed [23:0] x_offset;
  logic signed [23:0] y_offset;

  modport source (output valid, opcode, key_mask, delta_time, x_offset, y_offset,
                  input ready);
  modport sink (input valid, opcode, key_mask, delta_time, x_offset, y_offset,
                output ready);
endinterface

### src/fcpu_pose_if.sv
// fcpu_pose_if: pose result channel of the fly camera pose keeper
// depends on nothing
interface fcpu_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] front_x;
  logic signed [15:0] front_y;
  logic signed [15:0] front_z;
  logic [31:0]        cur_speed;
  logic signed [24:0] yaw_deg;
  logic signed [23:0] pitch_deg;

  modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                  cur_speed, yaw_deg, pitch_deg, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                cur_speed, yaw_deg, pitch_deg, output ready);
endinterface

### src/fcpu_mul.sv
// fcpu_mul: shared signed multiplier with registered product
// depends on nothing
module fcpu_mul (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [17:0] b,
  output logic signed [51:0] prod
);
  // registered product
  always_ff @(posedge clk) begin
    prod <= 52'(a) * 52'(b);
  end
endmodule

### src/fcpu_cordic.sv
// fcpu_cordic: iterative rotation-mode cordic, one micro-rotation per cycle
// depends on fcpu_pkg
module fcpu_cordic #(
  parameter int STEPS = fcpu_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC  = fcpu_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [24:0]     angle,
  output fcpu_pkg::cordic_res_t  res
);
  localparam int ZW    = FRAC + 10;
  localparam int XW    = FRAC + 3;
  localparam int IW    = $clog2(STEPS);
  localparam int LSH   = (FRAC >= 16) ? FRAC - 16 : 0;
  localparam int RSH   = (FRAC < 16) ? 16 - FRAC : 0;
  localparam int RHALF = (RSH > 0) ? (1 << (RSH - 1)) : 0;
  localparam int QRSH  = (FRAC >= 14) ? FRAC - 14 : 0;
  localparam int QLSH  = (FRAC < 14) ? 14 - FRAC : 0;
  localparam int QHALF = (QRSH > 0) ? (1 << (QRSH - 1)) : 0;
  localparam logic signed [ZW-1:0] Q90  = ZW'(64'sd90 <<< FRAC);
  localparam logic signed [ZW-1:0] Q180 = ZW'(64'sd180 <<< FRAC);
  localparam logic signed [XW-1:0] X0   = XW'(fcpu_pkg::GAIN_Q24 >>> (24 - FRAC));

  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic [IW-1:0]        i;
  logic                 busy, fin, neg;

  logic signed [41:0]   zt;
  logic signed [ZW-1:0] zf, zs;
  logic                 nf;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  logic signed [XW+2:0] cv, sv, cq, sq;
  logic signed [15:0]   cos_q, sin_q;

  // angle to internal format and fold into +-90
  always_comb begin
    zt = 42'(angle) <<< LSH;
    if (RSH > 0) zt = (zt + 42'(RHALF) - (zt[41] ? 42'sd1 : 42'sd0)) >>> RSH;
    zf = zt[ZW-1:0];
    nf = 1'b0;
    zs = zf;
    if (zf > Q90) begin
      zs = zf - Q180;
      nf = 1'b1;
    end else if (zf < -Q90) begin
      zs = zf + Q180;
      nf = 1'b1;
    end
  end

  // one micro-rotation
  always_comb begin
    dx = y >>> i;
    dy = x >>> i;
    at = ZW'(fcpu_pkg::atan_q24(5'(i)) >> (24 - FRAC));
  end

  // final sign and conversion to q2.14 with clamp
  always_comb begin
    cv = neg ? -(XW+3)'(x) : (XW+3)'(x);
    sv = neg ? -(XW+3)'(y) : (XW+3)'(y);
    if (FRAC >= 14) begin
      cq = (cv + (XW+3)'(QHALF) - (cv[XW+2] ? (XW+3)'(1) : (XW+3)'(0))) >>> QRSH;
      sq = (sv + (XW+3)'(QHALF) - (sv[XW+2] ? (XW+3)'(1) : (XW+3)'(0))) >>> QRSH;
    end else begin
      cq = cv <<< QLSH;
      sq = sv <<< QLSH;
    end
    if (cq > (XW+3)'(fcpu_pkg::UNIT_POS)) cos_q = fcpu_pkg::UNIT_POS;
    else if (cq < (XW+3)'(fcpu_pkg::UNIT_NEG)) cos_q = fcpu_pkg::UNIT_NEG;
    else cos_q = cq[15:0];
    if (sq > (XW+3)'(fcpu_pkg::UNIT_POS)) sin_q = fcpu_pkg::UNIT_POS;
    else if (sq < (XW+3)'(fcpu_pkg::UNIT_NEG)) sin_q = fcpu_pkg::UNIT_NEG;
    else sin_q = sq[15:0];
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= fin;
      fin      <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && i == IW'(STEPS - 1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x   <= X0;
      y   <= '0;
      z   <= zs;
      neg <= nf;
      i   <= '0;
    end else if (busy) begin
      if (!z[ZW-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
      i <= i + IW'(1);
    end
    if (fin) begin
      res.cos <= cos_q;
      res.sin <= sin_q;
    end
  end
endmodule

### src/fly_camera_pose_update.sv
// fly_camera_pose_update: scroll and home update the pose as the event is accepted and
// go straight to the result; move uses the shared multiplier for 6 products, and mouse
// look uses 2 gain products, 8 yaw wrap steps, two cordic runs (yaw, then pitch) and
// 2 front products
// result is held until taken, one transaction in flight at a time
// synchronous reset restores the home pose from the register reset values
module fly_camera_pose_update #(
  parameter int CORDIC_STEPS = fcpu_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = fcpu_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  fcpu_cmd_if.sink           cmd,
  fcpu_pose_if.source        pose
);
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MV0  = 5'd1;
  localparam logic [4:0] S_MV1  = 5'd2;
  localparam logic [4:0] S_MV2  = 5'd3;
  localparam logic [4:0] S_MV3  = 5'd4;
  localparam logic [4:0] S_MV4  = 5'd5;
  localparam logic [4:0] S_MV5  = 5'd6;
  localparam logic [4:0] S_MV6  = 5'd7;
  localparam logic [4:0] S_MV7  = 5'd8;
  localparam logic [4:0] S_MV8  = 5'd9;
  localparam logic [4:0] S_MS0  = 5'd10;
  localparam logic [4:0] S_MS1  = 5'd11;
  localparam logic [4:0] S_MS2  = 5'd12;
  localparam logic [4:0] S_RED  = 5'd13;
  localparam logic [4:0] S_CY0  = 5'd14;
  localparam logic [4:0] S_CY1  = 5'd15;
  localparam logic [4:0] S_CP1  = 5'd16;
  localparam logic [4:0] S_F0   = 5'd17;
  localparam logic [4:0] S_F1   = 5'd18;
  localparam logic [4:0] S_F2   = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;

  logic [4:0] state;

  // configuration registers
  logic signed [31:0] init_x, init_y, init_z;
  logic [31:0]        init_speed;
  logic [15:0]        look_gain;

  // pose state
  logic signed [31:0] px, py, pz;
  logic signed [15:0] fx, fy, fz;
  logic [31:0]        speed;
  logic signed [24:0] yaw;
  logic signed [23:0] pitch;
  logic signed [15:0] ysin, ycos, pcos;

  // captured transaction
  logic [5:0]         keys;
  logic [15:0]        dt;
  logic signed [23:0] xo, yo;

  // working registers
  logic [31:0]        vel;
  logic signed [33:0] t0, t1, t2, t3;
  logic signed [35:0] d0, d1, d2;
  logic [33:0]        red;
  logic [2:0]         k;

  logic signed [33:0] ma;
  logic signed [17:0] mb;
  logic signed [51:0] prod, pr14, pr8;

  logic                  cstart;
  logic signed [24:0]    cangle;
  fcpu_pkg::cordic_res_t cres;

  logic signed [34:0] scroll_s;
  logic signed [35:0] yr;
  logic signed [33:0] pn;
  logic [33:0]        sh, red_nx;
  logic signed [33:0] vs;

  assign pready = 1'b1;

  // register write and readback
  always_ff @(posedge clk) begin
    if (rst) begin
      init_x     <= '0;
      init_y     <= '0;
      init_z     <= '0;
      init_speed <= fcpu_pkg::SPEED_RST;
      look_gain  <= fcpu_pkg::GAIN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        fcpu_pkg::REG_INIT_X: init_x     <= pwdata;
        fcpu_pkg::REG_INIT_Y: init_y     <= pwdata;
        fcpu_pkg::REG_INIT_Z: init_z     <= pwdata;
        fcpu_pkg::REG_SPEED:  init_speed <= pwdata;
        fcpu_pkg::REG_GAIN:   look_gain  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      fcpu_pkg::REG_INIT_X: prdata = init_x;
      fcpu_pkg::REG_INIT_Y: prdata = init_y;
      fcpu_pkg::REG_INIT_Z: prdata = init_z;
      fcpu_pkg::REG_SPEED:  prdata = init_speed;
      fcpu_pkg::REG_GAIN:   prdata = {16'd0, look_gain};
      default:              prdata = '0;
    endcase
  end

  // shared units
  fcpu_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod(prod));

  fcpu_cordic #(.STEPS(CORDIC_STEPS), .FRAC(FRAC_BITS)) u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .angle(cangle), .res(cres)
  );

  assign cstart = (state == S_CY0) || (state == S_CY1 && cres.done);
  assign cangle = (state == S_CY0) ? yaw : 25'(pitch);

  // multiplier operand select
  always_comb begin
    ma = 34'({2'b00, vel});
    mb = 18'(fx);
    unique case (state)
      S_MV0: begin ma = 34'({2'b00, speed}); mb = 18'({2'b00, dt}); end
      S_MV3: mb = 18'(fy);
      S_MV4: mb = 18'(fz);
      S_MV5: mb = -18'(ysin);
      S_MV6: mb = 18'(ycos);
      S_MS0: begin ma = 34'(xo); mb = 18'({2'b00, look_gain}); end
      S_MS1: begin ma = 34'(yo); mb = 18'({2'b00, look_gain}); end
      S_F0:  begin ma = 34'(ycos); mb = 18'(pcos); end
      S_F1:  begin ma = 34'(ysin); mb = 18'(pcos); end
      default: ;
    endcase
  end

  // rounded product views, scroll, yaw wrap and pitch sum before the clamp
  always_comb begin
    pr14     = fcpu_pkg::rnd_shr(prod, 14);
    pr8      = fcpu_pkg::rnd_shr(prod, 8);
    scroll_s = 35'({1'b0, speed}) + (35'(cmd.y_offset) <<< 8);
    yr       = 36'(yaw) + 36'($signed(pr8[32:0])) + 36'(fcpu_pkg::YAW_HALF)
             + 36'(fcpu_pkg::YAW_FULL << 7);
    pn       = 34'(pitch) + 34'($signed(pr8[32:0]));
    sh       = fcpu_pkg::YAW_FULL << k;
    red_nx   = (red >= sh) ? red - sh : red;
    vs       = 34'({2'b00, vel});
  end

  // sequencer and pose update
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      px    <= '0;
      py    <= '0;
      pz    <= '0;
      speed <= fcpu_pkg::SPEED_RST;
      yaw   <= fcpu_pkg::YAW_HOME;
      pitch <= '0;
      fx    <= '0;
      fy    <= '0;
      fz    <= fcpu_pkg::UNIT_NEG;
      ysin  <= fcpu_pkg::UNIT_NEG;
      ycos  <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (cmd.valid) begin
          keys <= cmd.key_mask;
          dt   <= cmd.delta_time;
          xo   <= cmd.x_offset;
          yo   <= cmd.y_offset;
          unique case (cmd.opcode)
            fcpu_pkg::OP_MOVE: state <= S_MV0;
            fcpu_pkg::OP_LOOK: state <= S_MS0;
            fcpu_pkg::OP_SCROLL: begin
              if (scroll_s < 35'sd65536) speed <= fcpu_pkg::SPEED_MIN;
              else if (scroll_s > 35'sh0ffffffff) speed <= 32'hffffffff;
              else speed <= scroll_s[31:0];
              state <= S_OUT;
            end
            fcpu_pkg::OP_HOME: begin
              px    <= init_x;
              py    <= init_y;
              pz    <= init_z;
              speed <= (init_speed < fcpu_pkg::SPEED_MIN) ? fcpu_pkg::SPEED_MIN : init_speed;
              yaw   <= fcpu_pkg::YAW_HOME;
              pitch <= '0;
              fx    <= '0;
              fy    <= '0;
              fz    <= fcpu_pkg::UNIT_NEG;
              ysin  <= fcpu_pkg::UNIT_NEG;
              ycos  <= '0;
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        // move: velocity, then five unit products
        S_MV0: state <= S_MV1;
        S_MV1: begin vel <= prod[47:16]; state <= S_MV2; end
        S_MV2: state <= S_MV3;
        S_MV3: begin t0 <= pr14[33:0]; state <= S_MV4; end
        S_MV4: begin t1 <= pr14[33:0]; state <= S_MV5; end
        S_MV5: begin t2 <= pr14[33:0]; state <= S_MV6; end
        S_MV6: begin t3 <= pr14[33:0]; state <= S_MV7; end
        S_MV7: state <= S_MV8;
        S_MV8: begin
          px <= fcpu_pkg::sat32(37'(px) + 37'(d0));
          py <= fcpu_pkg::sat32(37'(py) + 37'(d1));
          pz <= fcpu_pkg::sat32(37'(pz) + 37'(d2));
          state <= S_OUT;
        end
        // mouse look: gain products, yaw wrap, pitch clamp
        S_MS0: state <= S_MS1;
        S_MS1: begin red <= yr[33:0]; state <= S_MS2; end
        S_MS2: begin
          if (pn > fcpu_pkg::PITCH_LIM) pitch <= fcpu_pkg::PITCH_LIM[23:0];
          else if (pn < -fcpu_pkg::PITCH_LIM) pitch <= 24'(-fcpu_pkg::PITCH_LIM);
          else pitch <= pn[23:0];
          k     <= 3'd7;
          state <= S_RED;
        end
        S_RED: begin
          red <= red_nx;
          k   <= k - 3'd1;
          if (k == 3'd0) begin
            yaw   <= 25'(red_nx - fcpu_pkg::YAW_HALF);
            state <= S_CY0;
          end
        end
        // front vector from yaw and pitch rotations
        S_CY0: state <= S_CY1;
        S_CY1: if (cres.done) begin
          ysin  <= cres.sin;
          ycos  <= cres.cos;
          state <= S_CP1;
        end
        S_CP1: if (cres.done) begin
          fy    <= cres.sin;
          pcos  <= cres.cos;
          state <= S_F0;
        end
        S_F0: state <= S_F1;
        S_F1: begin fx <= pr14[15:0]; state <= S_F2; end
        S_F2: begin fz <= pr14[15:0]; state <= S_OUT; end
        S_OUT: if (pose.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // per-axis sums of pressed keys, opposite keys cancel
  always_ff @(posedge clk) begin
    if (state == S_MV7) begin
      d0 <= (keys[0] && !keys[1] ? 36'(t0) : keys[1] && !keys[0] ? -36'(t0) : 36'sd0)
          + (keys[3] && !keys[2] ? 36'(t3) : keys[2] && !keys[3] ? -36'(t3) : 36'sd0);
      d1 <= (keys[0] && !keys[1] ? 36'(t1) : keys[1] && !keys[0] ? -36'(t1) : 36'sd0)
          + (keys[4] && !keys[5] ? 36'(vs) : keys[5] && !keys[4] ? -36'(vs) : 36'sd0);
      d2 <= (keys[0] && !keys[1] ? 36'(t2) : keys[1] && !keys[0] ? -36'(t2) : 36'sd0)
          + (keys[3] && !keys[2] ? 36'($signed(pr14[33:0])) :
             keys[2] && !keys[3] ? -36'($signed(pr14[33:0])) : 36'sd0);
    end
  end

  // channel handshakes and result payload
  assign cmd.ready      = (state == S_IDLE);
  assign pose.valid     = (state == S_OUT);
  assign pose.pos_x     = px;
  assign pose.pos_y     = py;
  assign pose.pos_z     = pz;
  assign pose.front_x   = fx;
  assign pose.front_y   = fy;
  assign pose.front_z   = fz;
  assign pose.cur_speed = speed;
  assign pose.yaw_deg   = yaw;
  assign pose.pitch_deg = pitch;
endmodule

### verif/tb_top.sv
// tb_top: self-checking testbench of fly_camera_pose_update
// depends on fcpu_pkg, fcpu_cmd_if, fcpu_pose_if and the block itself
module tb_top;

  // one expected pose after an event
  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] fx, fy, fz;
    logic [31:0]        spd;
    logic signed [24:0] yaw;
    logic signed [23:0] pitch;
  } pose_t;

  // pose predictor plus queue of poses still owed by the block
  class pose_scoreboard;
    int    cam[3];
    int    yaw_q16, pitch_q16;
    longint unsigned speed;
    int    front[3];
    int    ysin, ycos;
    int    home[3];
    longint unsigned home_speed;
    longint unsigned gain;
    pose_t expected_poses[$];
    int    mismatches;
    int    checked;
    longint atan_tab[12] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                             30029717, 15018523, 7509720, 3754917, 1877466,
                             938734, 469367};

    function new();
      home = '{0, 0, 0};
      home_speed = fcpu_pkg::SPEED_RST;
      gain = fcpu_pkg::GAIN_RST;
      mismatches = 0;
      checked = 0;
      go_home();
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        fcpu_pkg::REG_INIT_X: home[0] = $signed(val);
        fcpu_pkg::REG_INIT_Y: home[1] = $signed(val);
        fcpu_pkg::REG_INIT_Z: home[2] = $signed(val);
        fcpu_pkg::REG_SPEED:  home_speed = val;
        fcpu_pkg::REG_GAIN:   gain = val[15:0];
        default: ;
      endcase
    endfunction

    function void go_home();
      cam = home;
      speed = (home_speed < 65536) ? 65536 : home_speed;
      yaw_q16 = fcpu_pkg::YAW_HOME;
      pitch_q16 = 0;
      front = '{0, 0, -16384};
      ysin = -16384;
      ycos = 0;
    endfunction

    // shift right rounding half away from zero
    function longint rshr(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) << (s - 1))) >> s;
      return (v < 0) ? -m : m;
    endfunction

    function int to_unit(longint v);
      v = rshr(v, 2);
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return int'(v);
    endfunction

    function int sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    // rotation cordic, 16 steps with 16 fraction bits
    task automatic sincos(input int deg, output int sn, output int cs);
      longint z, x, y, dx, dy, a, q90;
      bit neg;
      q90 = longint'(90) << 16;
      z = deg;
      neg = 0;
      if (z > q90) begin
        z -= 2 * q90;
        neg = 1;
      end else if (z < -q90) begin
        z += 2 * q90;
        neg = 1;
      end
      x = fcpu_pkg::GAIN_Q24 >>> 8;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        a = ((i < 12) ? atan_tab[i] : (fcpu_pkg::DEG_RAD_Q24 >>> i)) >>> 8;
        if (z >= 0) begin
          x -= dx; y += dy; z -= a;
        end else begin
          x += dx; y -= dy; z += a;
        end
      end
      if (neg) begin
        x = -x;
        y = -y;
      end
      cs = to_unit(x);
      sn = to_unit(y);
    endtask

    // accepted event: advance the pose and queue it
    task automatic note_event(logic [1:0] op, logic [5:0] keys, logic [15:0] dt,
                              logic signed [23:0] xo, logic signed [23:0] yo);
      longint v, fwd, side, upd, r, p, s;
      longint d[3];
      int sp, cp;
      pose_t e;
      case (op)
        fcpu_pkg::OP_MOVE: begin
          v = (longint'(speed) * longint'(dt)) >> 16;
          fwd = longint'(keys[0]) - longint'(keys[1]);
          side = longint'(keys[3]) - longint'(keys[2]);
          upd = longint'(keys[4]) - longint'(keys[5]);
          d[0] = fwd * rshr(v * front[0], 14) + side * rshr(v * -longint'(ysin), 14);
          d[1] = fwd * rshr(v * front[1], 14) + upd * v;
          d[2] = fwd * rshr(v * front[2], 14) + side * rshr(v * longint'(ycos), 14);
          for (int k = 0; k < 3; k++) cam[k] = sat(longint'(cam[k]) + d[k]);
        end
        fcpu_pkg::OP_LOOK: begin
          r = (longint'(yaw_q16) + rshr(longint'(xo) * longint'(gain), 8)
               + longint'(fcpu_pkg::YAW_HALF)) % longint'(fcpu_pkg::YAW_FULL);
          if (r < 0) r += longint'(fcpu_pkg::YAW_FULL);
          yaw_q16 = int'(r - longint'(fcpu_pkg::YAW_HALF));
          p = longint'(pitch_q16) + rshr(longint'(yo) * longint'(gain), 8);
          if (p > longint'(fcpu_pkg::PITCH_LIM)) p = longint'(fcpu_pkg::PITCH_LIM);
          if (p < -longint'(fcpu_pkg::PITCH_LIM)) p = -longint'(fcpu_pkg::PITCH_LIM);
          pitch_q16 = int'(p);
          sincos(yaw_q16, ysin, ycos);
          sincos(pitch_q16, sp, cp);
          front[0] = int'(rshr(longint'(ycos) * cp, 14));
          front[1] = sp;
          front[2] = int'(rshr(longint'(ysin) * cp, 14));
        end
        fcpu_pkg::OP_SCROLL: begin
          s = longint'(speed) + longint'(yo) * 256;
          if (s < 65536) s = 65536;
          if (s > 64'sh00000000FFFFFFFF) s = 64'sh00000000FFFFFFFF;
          speed = s;
        end
        default: go_home();
      endcase
      e.px = cam[0]; e.py = cam[1]; e.pz = cam[2];
      e.fx = front[0]; e.fy = front[1]; e.fz = front[2];
      e.spd = speed[31:0];
      e.yaw = yaw_q16[24:0];
      e.pitch = pitch_q16[23:0];
      expected_poses.push_back(e);
    endtask

    function void check_pose(pose_t got);
      pose_t e;
      checked++;
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose transaction, none pending");
        return;
      end
      e = expected_poses.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("pose mismatch #%0d: exp pos %0d %0d %0d front %0d %0d %0d",
                   checked, e.px, e.py, e.pz, e.fx, e.fy, e.fz);
          $display("  exp spd %0d yaw %0d pitch %0d", e.spd, e.yaw, e.pitch);
          $display("  got pos %0d %0d %0d front %0d %0d %0d",
                   got.px, got.py, got.pz, got.fx, got.fy, got.fz);
          $display("  got spd %0d yaw %0d pitch %0d", got.spd, got.yaw, got.pitch);
        end
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fcpu_cmd_if  cmd_ch();
  fcpu_pose_if pose_ch();

  fly_camera_pose_update DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd(cmd_ch), .pose(pose_ch)
  );

  pose_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int events_sent = 0;
  int quiet_cycles = 0;
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  always #10 clk = ~clk;

  initial begin
    cmd_ch.valid = 0;
    cmd_ch.opcode = '0;
    cmd_ch.key_mask = '0;
    cmd_ch.delta_time = '0;
    cmd_ch.x_offset = '0;
    cmd_ch.y_offset = '0;
    pose_ch.ready = 0;
  end

  // receiver: random stalls plus long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      pose_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      pose_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // pose monitor and watchdog
  always @(posedge clk) begin
    pose_t got;
    if (!rst && pose_ch.valid && pose_ch.ready) begin
      got.px = pose_ch.pos_x; got.py = pose_ch.pos_y; got.pz = pose_ch.pos_z;
      got.fx = pose_ch.front_x; got.fy = pose_ch.front_y; got.fz = pose_ch.front_z;
      got.spd = pose_ch.cur_speed;
      got.yaw = pose_ch.yaw_deg;
      got.pitch = pose_ch.pitch_deg;
      sb.check_pose(got);
    end
    if ((cmd_ch.valid && cmd_ch.ready) || (pose_ch.valid && pose_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog expired with %0d poses pending", sb.expected_poses.size());
      $display("status: fail");
      $finish;
    end
  end

  // apb write: setup then access cycle
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_event(logic [1:0] op, logic [5:0] keys, logic [15:0] dt,
                            logic [23:0] xo, logic [23:0] yo);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      cmd_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1;
    cmd_ch.opcode <= op;
    cmd_ch.key_mask <= keys;
    cmd_ch.delta_time <= dt;
    cmd_ch.x_offset <= xo;
    cmd_ch.y_offset <= yo;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    sb.note_event(op, keys, dt, xo, yo);
    events_sent++;
  endtask

  // mostly sensible events with random content, some full-range noise
  task automatic send_random_event();
    int r;
    logic [23:0] xo, yo;
    logic [15:0] dt;
    r = $urandom_range(99);
    xo = 24'($urandom);
    yo = 24'($urandom);
    dt = 16'($urandom);
    if (r < 40) begin
      if ($urandom_range(3) != 0) dt = 16'($urandom_range(4000));
      send_event(fcpu_pkg::OP_MOVE, 6'($urandom), dt, xo, yo);
    end else if (r < 70) begin
      if ($urandom_range(4) != 0) begin
        xo = 24'($urandom_range(8191) - 4096);
        yo = 24'($urandom_range(8191) - 4096);
      end
      send_event(fcpu_pkg::OP_LOOK, 6'($urandom), dt, xo, yo);
    end else if (r < 85) begin
      if ($urandom_range(3) != 0) yo = 24'($urandom_range(2047) - 1024);
      send_event(fcpu_pkg::OP_SCROLL, 6'($urandom), dt, xo, yo);
    end else begin
      send_event(fcpu_pkg::OP_HOME, 6'($urandom), dt, xo, yo);
    end
  endtask

  task automatic drain();
    cmd_ch.valid <= 0;
    while (sb.expected_poses.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed events at reset register values
    send_event(fcpu_pkg::OP_MOVE, 6'b000001, 16'hFFFF, 0, 0);
    send_event(fcpu_pkg::OP_MOVE, 6'b000010, 16'h8000, 0, 0);
    send_event(fcpu_pkg::OP_MOVE, 6'b000100, 16'h4000, 0, 0);
    send_event(fcpu_pkg::OP_MOVE, 6'b001000, 16'h4000, 0, 0);
    send_event(fcpu_pkg::OP_MOVE, 6'b010000, 16'h0001, 0, 0);
    send_event(fcpu_pkg::OP_MOVE, 6'b100000, 16'h1234, 0, 0);
    send_event(fcpu_pkg::OP_MOVE, 6'b111111, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_event(fcpu_pkg::OP_MOVE, 6'b001101, 16'h0000, 0, 0);
    send_event(fcpu_pkg::OP_LOOK, 0, 0, 24'h7FFFFF, 24'h7FFFFF);
    send_event(fcpu_pkg::OP_LOOK, 0, 0, 24'h800000, 24'h800000);
    send_event(fcpu_pkg::OP_LOOK, 0, 0, 24'd900, 24'd400);
    send_event(fcpu_pkg::OP_MOVE, 6'b011001, 16'h2000, 0, 0);
    send_event(fcpu_pkg::OP_LOOK, 6'h3F, 16'hFFFF, -24'sd2000, -24'sd100);
    send_event(fcpu_pkg::OP_MOVE, 6'b001010, 16'h7FFF, 0, 0);
    send_event(fcpu_pkg::OP_SCROLL, 0, 0, 0, 24'h800000);
    send_event(fcpu_pkg::OP_SCROLL, 0, 0, 0, 24'h7FFFFF);
    send_event(fcpu_pkg::OP_SCROLL, 0, 0, 0, 24'h7FFFFF);
    send_event(fcpu_pkg::OP_SCROLL, 0, 0, 0, 24'h7FFFFF);
    repeat (3) send_event(fcpu_pkg::OP_MOVE, 6'b010001, 16'hFFFF, 0, 0);
    send_event(fcpu_pkg::OP_MOVE, 6'b100010, 16'hFFFF, 0, 0);
    send_event(fcpu_pkg::OP_HOME, 6'h3F, 16'hFFFF, 24'h7FFFFF, 24'h800000);
    send_event(fcpu_pkg::OP_MOVE, 6'b000001, 16'h1000, 0, 0);
    drain();

    // phase one: extreme registers, receiver slow, long hold-off
    reg_write(fcpu_pkg::REG_INIT_X, 32'h7FFFFFFF);
    reg_write(fcpu_pkg::REG_INIT_Y, 32'h80000000);
    reg_write(fcpu_pkg::REG_INIT_Z, $urandom);
    reg_write(fcpu_pkg::REG_SPEED, 32'h0);
    reg_write(fcpu_pkg::REG_GAIN, 32'h0000FFFF);
    send_idle_pct = 23;
    recv_idle_pct = 65;
    send_event(fcpu_pkg::OP_HOME, 0, 0, 0, 0);
    for (int i = 0; i < 170; i++) begin
      if (i == 40) hold_cycles = 300;
      send_random_event();
    end
    drain();

    // phase two: fast receiver, slow sender, one full pause
    reg_write(fcpu_pkg::REG_INIT_X, $urandom);
    reg_write(fcpu_pkg::REG_INIT_Y, $urandom);
    reg_write(fcpu_pkg::REG_INIT_Z, 32'h80000000);
    reg_write(fcpu_pkg::REG_SPEED, 32'hFFFFFFFF);
    reg_write(fcpu_pkg::REG_GAIN, 32'h0);
    send_idle_pct = 65;
    recv_idle_pct = 23;
    send_event(fcpu_pkg::OP_HOME, 0, 0, 0, 0);
    for (int i = 0; i < 165; i++) begin
      if (i == 80) begin
        cmd_ch.valid <= 0;
        while (sb.expected_poses.size() > 0) @(posedge clk);
      end
      send_random_event();
    end
    drain();

    // phase three: mid-range registers, no idling
    reg_write(fcpu_pkg::REG_INIT_X, 32'($urandom_range(2000000) - 1000000));
    reg_write(fcpu_pkg::REG_INIT_Y, 32'($urandom_range(2000000) - 1000000));
    reg_write(fcpu_pkg::REG_INIT_Z, 32'($urandom_range(2000000) - 1000000));
    reg_write(fcpu_pkg::REG_SPEED, 32'(32'd65536 + $urandom_range(500000)));
    reg_write(fcpu_pkg::REG_GAIN, 32'($urandom_range(65535)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_event(fcpu_pkg::OP_HOME, 0, 0, 0, 0);
    for (int i = 0; i < 165; i++) send_random_event();
    drain();

    $display("sent %0d events (move, look, scroll, home) over four register settings,",
             events_sent);
    $display("checked %0d poses under mixed sender and receiver stalls", sb.checked);
    if (sb.mismatches == 0 && sb.expected_poses.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d poses never seen", sb.mismatches,
               sb.expected_poses.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule
